@@ design/tsrc_pkg.sv @@
package tsrc_pkg;

    // Field widths fixed by the interface.
    localparam int unsigned TimeWidth    = 32;
    localparam int unsigned AttemptWidth = 16;
    localparam int unsigned CfgIdxWidth  = 3;

    // Configuration register indexes.
    localparam logic [CfgIdxWidth-1:0] CFG_SYNC_ENABLED     = 3'd0;
    localparam logic [CfgIdxWidth-1:0] CFG_DISPATCH_TIMEOUT = 3'd1;
    localparam logic [CfgIdxWidth-1:0] CFG_RESOLVE_TIMEOUT  = 3'd2;
    localparam logic [CfgIdxWidth-1:0] CFG_REPLY_TIMEOUT    = 3'd3;
    localparam logic [CfgIdxWidth-1:0] CFG_RETRY_INTERVAL   = 3'd4;
    localparam logic [CfgIdxWidth-1:0] CFG_RESYNC_INTERVAL  = 3'd5;

    // Reset values of the configuration registers.
    localparam logic [TimeWidth-1:0] RST_DISPATCH_TIMEOUT = 32'd5000;
    localparam logic [TimeWidth-1:0] RST_RESOLVE_TIMEOUT  = 32'd10000;
    localparam logic [TimeWidth-1:0] RST_REPLY_TIMEOUT    = 32'd5000;
    localparam logic [TimeWidth-1:0] RST_RETRY_INTERVAL   = 32'd60000;
    localparam logic [TimeWidth-1:0] RST_RESYNC_INTERVAL  = 32'd86400000;

    localparam logic [AttemptWidth-1:0] ATTEMPT_MAX = '1;

    // Client state codes as reported on the result channel.
    localparam logic [2:0] STATE_IDLE      = 3'd0;
    localparam logic [2:0] STATE_DISPATCH  = 3'd1;
    localparam logic [2:0] STATE_RESOLVE   = 3'd2;
    localparam logic [2:0] STATE_REQUESTED = 3'd3;
    localparam logic [2:0] STATE_SYNCED    = 3'd4;
    localparam logic [2:0] STATE_RETRY     = 3'd5;

    typedef enum logic [1:0] {
        KIND_TICK   = 2'd0,
        KIND_NET_UP = 2'd1,
        KIND_FORCE  = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        PHASE_NONE         = 3'd0,
        PHASE_DISPATCH     = 3'd1,
        PHASE_RESOLVE      = 3'd2,
        PHASE_SENT         = 3'd3,
        PHASE_READY        = 3'd4,
        PHASE_RESOLVE_FAIL = 3'd5,
        PHASE_SEND_FAIL    = 3'd6
    } phase_t;

    typedef enum logic [1:0] {
        CMD_NONE  = 2'd0,
        CMD_START = 2'd1,
        CMD_CLEAR = 2'd2,
        CMD_REARM = 2'd3
    } cmd_t;

    // Client state machine, one-hot.
    typedef enum logic [5:0] {
        MODE_IDLE      = 6'b000001,
        MODE_DISPATCH  = 6'b000010,
        MODE_RESOLVE   = 6'b000100,
        MODE_REQUESTED = 6'b001000,
        MODE_SYNCED    = 6'b010000,
        MODE_RETRY     = 6'b100000
    } mode_t;

    typedef struct packed {
        logic                 sync_enabled;
        logic [TimeWidth-1:0] dispatch_timeout_ms;
        logic [TimeWidth-1:0] resolve_timeout_ms;
        logic [TimeWidth-1:0] reply_timeout_ms;
        logic [TimeWidth-1:0] retry_interval_ms;
        logic [TimeWidth-1:0] resync_interval_ms;
    } cfg_t;

    typedef struct packed {
        logic [1:0]           kind;
        logic [TimeWidth-1:0] now_ms;
        logic [2:0]           job_phase;
        logic                 dispatch_accepted;
        logic                 reply_ok;
        logic [TimeWidth-1:0] reply_seconds;
        logic [TimeWidth-1:0] sent_stamp_ms;
        logic [TimeWidth-1:0] rx_stamp_ms;
    } item_t;

    typedef struct packed {
        mode_t                   mode;
        logic [TimeWidth-1:0]    mode_since_ms;
        logic [TimeWidth-1:0]    resync_deadline_ms;
        logic [AttemptWidth-1:0] attempts;
        logic                    synced;
        logic                    request_pending;
        logic [TimeWidth-1:0]    last_round_trip;
    } state_t;

    typedef struct packed {
        logic [2:0]              client_state;
        logic                    synced_flag;
        logic [AttemptWidth-1:0] attempt_count;
        logic [1:0]              job_command;
        logic                    set_time_strobe;
        logic [TimeWidth-1:0]    set_time_seconds;
        logic [TimeWidth-1:0]    round_trip_ms;
        logic                    request_accepted;
    } result_t;

    // Map the one-hot mode onto the reported state code.
    function automatic logic [2:0] mode_code(input mode_t mode);
        logic [2:0] code;
        unique case (mode)
            MODE_DISPATCH:  code = STATE_DISPATCH;
            MODE_RESOLVE:   code = STATE_RESOLVE;
            MODE_REQUESTED: code = STATE_REQUESTED;
            MODE_SYNCED:    code = STATE_SYNCED;
            MODE_RETRY:     code = STATE_RETRY;
            default:        code = STATE_IDLE;
        endcase
        return code;
    endfunction

endpackage

@@ design/tsrc_cfg_regs.sv @@
module tsrc_cfg_regs (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   cfg_we,
    input  logic [tsrc_pkg::CfgIdxWidth-1:0]       cfg_index,
    input  logic [tsrc_pkg::TimeWidth-1:0]         cfg_wdata,
    output tsrc_pkg::cfg_t                         cfg
);

    tsrc_pkg::cfg_t cfg_reg;
    tsrc_pkg::cfg_t cfg_next;

    // Decode the register index; unknown indexes are dropped.
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            unique case (cfg_index)
                tsrc_pkg::CFG_SYNC_ENABLED:     cfg_next.sync_enabled = cfg_wdata[0];
                tsrc_pkg::CFG_DISPATCH_TIMEOUT: cfg_next.dispatch_timeout_ms = cfg_wdata;
                tsrc_pkg::CFG_RESOLVE_TIMEOUT:  cfg_next.resolve_timeout_ms = cfg_wdata;
                tsrc_pkg::CFG_REPLY_TIMEOUT:    cfg_next.reply_timeout_ms = cfg_wdata;
                tsrc_pkg::CFG_RETRY_INTERVAL:   cfg_next.retry_interval_ms = cfg_wdata;
                tsrc_pkg::CFG_RESYNC_INTERVAL:  cfg_next.resync_interval_ms = cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.sync_enabled        <= 1'b1;
            cfg_reg.dispatch_timeout_ms <= tsrc_pkg::RST_DISPATCH_TIMEOUT;
            cfg_reg.resolve_timeout_ms  <= tsrc_pkg::RST_RESOLVE_TIMEOUT;
            cfg_reg.reply_timeout_ms    <= tsrc_pkg::RST_REPLY_TIMEOUT;
            cfg_reg.retry_interval_ms   <= tsrc_pkg::RST_RETRY_INTERVAL;
            cfg_reg.resync_interval_ms  <= tsrc_pkg::RST_RESYNC_INTERVAL;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

@@ design/tsrc_step_logic.sv @@
module tsrc_step_logic (
    input  tsrc_pkg::item_t   item,
    input  tsrc_pkg::cfg_t    cfg,
    input  tsrc_pkg::state_t  cur,
    output tsrc_pkg::state_t  nxt,
    output tsrc_pkg::result_t res
);

    typedef struct packed {
        tsrc_pkg::mode_t  mode;
        logic             take;
        tsrc_pkg::phase_t phase;
        tsrc_pkg::cmd_t   cmd;
    } start_t;

    // Outcome of starting a request: idle when sync is off, retry when the
    // transport refuses the job, dispatching otherwise.
    function automatic start_t start_req(input logic en, input logic acc);
        start_t s;
        s.take = en;
        if (!en) begin
            s.mode  = tsrc_pkg::MODE_IDLE;
            s.phase = tsrc_pkg::PHASE_NONE;
            s.cmd   = tsrc_pkg::CMD_NONE;
        end else if (!acc) begin
            s.mode  = tsrc_pkg::MODE_RETRY;
            s.phase = tsrc_pkg::PHASE_NONE;
            s.cmd   = tsrc_pkg::CMD_CLEAR;
        end else begin
            s.mode  = tsrc_pkg::MODE_DISPATCH;
            s.phase = tsrc_pkg::PHASE_DISPATCH;
            s.cmd   = tsrc_pkg::CMD_START;
        end
        return s;
    endfunction

    always_comb begin
        tsrc_pkg::phase_t              phase;
        tsrc_pkg::cmd_t                cmd;
        start_t                        st;
        logic                          strobe;
        logic [tsrc_pkg::TimeWidth-1:0] secs;
        logic                          req_acc;
        logic [tsrc_pkg::TimeWidth-1:0] elapsed;
        logic [tsrc_pkg::TimeWidth-1:0] limit;
        logic [tsrc_pkg::TimeWidth-1:0] to_deadline;
        logic                          resolving;

        nxt         = cur;
        phase       = tsrc_pkg::phase_t'(item.job_phase);
        cmd         = tsrc_pkg::CMD_NONE;
        st          = start_req(cfg.sync_enabled, item.dispatch_accepted);
        strobe      = 1'b0;
        secs        = '0;
        req_acc     = 1'b0;
        elapsed     = '0;
        limit       = '0;
        to_deadline = '0;
        resolving   = 1'b0;

        unique case (item.kind)
            tsrc_pkg::KIND_NET_UP: begin
                nxt.synced          = 1'b0;
                nxt.attempts        = '0;
                nxt.request_pending = 1'b1;
            end
            tsrc_pkg::KIND_FORCE: begin
                if (cfg.sync_enabled) begin
                    nxt.synced          = 1'b0;
                    nxt.request_pending = 1'b1;
                    req_acc             = 1'b1;
                end
            end
            tsrc_pkg::KIND_TICK: begin
                // A pending request starts unless a query is already in flight.
                if (cur.request_pending) begin
                    nxt.request_pending = 1'b0;
                    if (cur.mode != tsrc_pkg::MODE_DISPATCH &&
                        cur.mode != tsrc_pkg::MODE_RESOLVE &&
                        cur.mode != tsrc_pkg::MODE_REQUESTED) begin
                        nxt.mode = st.mode;
                        if (st.take) begin
                            nxt.mode_since_ms = item.now_ms;
                            phase             = st.phase;
                            cmd               = st.cmd;
                        end
                    end
                end

                elapsed     = item.now_ms - nxt.mode_since_ms;
                to_deadline = item.now_ms - nxt.resync_deadline_ms;

                // Run the client state machine on the updated mode.
                unique case (nxt.mode)
                    tsrc_pkg::MODE_DISPATCH, tsrc_pkg::MODE_RESOLVE: begin
                        resolving = (nxt.mode == tsrc_pkg::MODE_RESOLVE);
                        limit     = resolving ? cfg.resolve_timeout_ms
                                              : cfg.dispatch_timeout_ms;
                        if (phase == tsrc_pkg::PHASE_SENT ||
                            phase == tsrc_pkg::PHASE_READY) begin
                            if (nxt.attempts != tsrc_pkg::ATTEMPT_MAX) begin
                                nxt.attempts = nxt.attempts + 1'b1;
                            end
                            nxt.mode          = tsrc_pkg::MODE_REQUESTED;
                            nxt.mode_since_ms = item.now_ms;
                        end else if (phase == tsrc_pkg::PHASE_RESOLVE && !resolving) begin
                            nxt.mode          = tsrc_pkg::MODE_RESOLVE;
                            nxt.mode_since_ms = item.now_ms;
                        end else if (phase == tsrc_pkg::PHASE_RESOLVE_FAIL ||
                                     phase == tsrc_pkg::PHASE_SEND_FAIL ||
                                     elapsed > limit) begin
                            nxt.mode          = tsrc_pkg::MODE_RETRY;
                            nxt.mode_since_ms = item.now_ms;
                        end
                    end
                    tsrc_pkg::MODE_REQUESTED: begin
                        if (phase == tsrc_pkg::PHASE_READY) begin
                            if (item.reply_ok) begin
                                nxt.last_round_trip    = item.rx_stamp_ms - item.sent_stamp_ms;
                                nxt.synced             = 1'b1;
                                nxt.mode               = tsrc_pkg::MODE_SYNCED;
                                nxt.resync_deadline_ms = item.now_ms + cfg.resync_interval_ms;
                                if (item.reply_seconds != '0) begin
                                    strobe = 1'b1;
                                    secs   = item.reply_seconds;
                                end
                            end else begin
                                cmd = tsrc_pkg::CMD_REARM;
                            end
                        end else if (elapsed > cfg.reply_timeout_ms) begin
                            nxt.mode          = tsrc_pkg::MODE_RETRY;
                            nxt.mode_since_ms = item.now_ms;
                        end
                    end
                    tsrc_pkg::MODE_RETRY, tsrc_pkg::MODE_SYNCED: begin
                        // Retry pause over, or resync deadline reached.
                        if ((nxt.mode == tsrc_pkg::MODE_RETRY &&
                             elapsed >= cfg.retry_interval_ms) ||
                            (nxt.mode == tsrc_pkg::MODE_SYNCED &&
                             !to_deadline[tsrc_pkg::TimeWidth-1])) begin
                            nxt.mode = st.mode;
                            if (st.take) begin
                                nxt.mode_since_ms = item.now_ms;
                                cmd               = st.cmd;
                            end
                        end
                    end
                    default: ;
                endcase
            end
            default: ;
        endcase

        res.client_state     = tsrc_pkg::mode_code(nxt.mode);
        res.synced_flag      = nxt.synced;
        res.attempt_count    = nxt.attempts;
        res.job_command      = cmd;
        res.set_time_strobe  = strobe;
        res.set_time_seconds = secs;
        res.round_trip_ms    = nxt.last_round_trip;
        res.request_accepted = req_acc;
    end

endmodule

@@ design/time_sync_retry_controller.sv @@
// Network time query sequencer. Each request on the s_ channel is a tick, a
// network-up event or a forced-sync request; each produces exactly one result
// on the m_ channel carrying the client state after the event, the job command
// for the transport, and a set-time strobe with the reply seconds. The block
// takes one request per clock: a request is registered, then one combinational
// pass over the client state and the configuration produces the next state
// and the result, which is held in an output register. A request passes from the
// input register to the output register, where its result is valid; while a
// result waits on m_ready, the next request is held in the input register and
// s_ready drops. The configuration port is a plain write port and must only be
// written while no request is in flight.
module time_sync_retry_controller (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_wdata,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_kind,
    input  logic [31:0] s_now_ms,
    input  logic [2:0]  s_job_phase,
    input  logic        s_dispatch_accepted,
    input  logic        s_reply_ok,
    input  logic [31:0] s_reply_seconds,
    input  logic [31:0] s_sent_stamp_ms,
    input  logic [31:0] s_rx_stamp_ms,

    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_client_state,
    output logic        m_synced_flag,
    output logic [15:0] m_attempt_count,
    output logic [1:0]  m_job_command,
    output logic        m_set_time_strobe,
    output logic [31:0] m_set_time_seconds,
    output logic [31:0] m_round_trip_ms,
    output logic        m_request_accepted
);

    tsrc_pkg::cfg_t    cfg;
    tsrc_pkg::item_t   item_reg;
    tsrc_pkg::item_t   item_next;
    logic              in_valid_reg;
    logic              in_valid_next;
    tsrc_pkg::state_t  state_reg;
    tsrc_pkg::state_t  state_next;
    tsrc_pkg::result_t res_reg;
    tsrc_pkg::result_t res_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic              advance;
    logic              s_fire;

    tsrc_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    tsrc_step_logic u_step (
        .item (item_reg),
        .cfg  (cfg),
        .cur  (state_reg),
        .nxt  (state_next),
        .res  (res_next)
    );

    // The registered request moves on whenever the result register is free.
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign s_fire  = s_valid && s_ready;

    always_comb begin
        item_next.kind              = s_kind;
        item_next.now_ms            = s_now_ms;
        item_next.job_phase         = s_job_phase;
        item_next.dispatch_accepted = s_dispatch_accepted;
        item_next.reply_ok          = s_reply_ok;
        item_next.reply_seconds     = s_reply_seconds;
        item_next.sent_stamp_ms     = s_sent_stamp_ms;
        item_next.rx_stamp_ms       = s_rx_stamp_ms;
    end

    // Handshake bookkeeping for both register stages.
    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_fire) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (advance) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    // Control and client state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg                 <= 1'b0;
            out_valid_reg                <= 1'b0;
            state_reg.mode               <= tsrc_pkg::MODE_IDLE;
            state_reg.mode_since_ms      <= '0;
            state_reg.resync_deadline_ms <= '0;
            state_reg.attempts           <= '0;
            state_reg.synced             <= 1'b0;
            state_reg.request_pending    <= 1'b0;
            state_reg.last_round_trip    <= '0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance) begin
                state_reg <= state_next;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            item_reg <= item_next;
        end
        if (advance) begin
            res_reg <= res_next;
        end
    end

    assign m_valid            = out_valid_reg;
    assign m_client_state     = res_reg.client_state;
    assign m_synced_flag      = res_reg.synced_flag;
    assign m_attempt_count    = res_reg.attempt_count;
    assign m_job_command      = res_reg.job_command;
    assign m_set_time_strobe  = res_reg.set_time_strobe;
    assign m_set_time_seconds = res_reg.set_time_seconds;
    assign m_round_trip_ms    = res_reg.round_trip_ms;
    assign m_request_accepted = res_reg.request_accepted;

`ifndef ASSERT_OFF
    // Client state changes only when a request passes through the logic.
    a_state_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !advance |=> $stable(state_reg))
        else $error("client state changed without a request");

    // A registered request is never dropped while the output is stalled.
    a_item_kept: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !advance |=> in_valid_reg)
        else $error("registered request lost");

    // Only a network-up event may lower the attempt count.
    a_attempts_mono: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && item_reg.kind != tsrc_pkg::KIND_NET_UP
        |=> state_reg.attempts >= $past(state_reg.attempts))
        else $error("attempt count decreased");

    // A time load only comes with a fresh sync.
    a_strobe_synced: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && res_reg.set_time_strobe
        |-> res_reg.synced_flag && res_reg.client_state == tsrc_pkg::STATE_SYNCED
            && res_reg.set_time_seconds != '0)
        else $error("set-time strobe outside a sync");

    // Without a strobe the seconds field reads zero.
    a_secs_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && !res_reg.set_time_strobe |-> res_reg.set_time_seconds == '0)
        else $error("seconds present without strobe");
`endif

endmodule
